// ===== rtl/m3au_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package m3au_pkg;

   // number format and datapath widths
   localparam int DATA_W   = 32;
   localparam int FRAC_W   = 16;
   localparam int OPND_W   = DATA_W + 1;
   localparam int PROD_W   = 2 * OPND_W;
   localparam int ACC_W    = 3 * DATA_W + 3;

   localparam int NUM_ELEM = 9;
   localparam int IDX_W    = 4;
   localparam int CMD_W    = 2;
   localparam int OP_W     = 3;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = ((IDX_W + DATA_W + OP_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((DATA_W + IDX_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_RUN    = 2'd2
   } cmd_type;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_MUL    = 3'd2,
      OP_SCALE  = 3'd3,
      OP_MATVEC = 3'd4,
      OP_TRANS  = 3'd5,
      OP_DET    = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      X_A,
      X_B,
      X_HOLD
   } x_sel_type;

   typedef enum logic [2:0] {
      Y_ONE,
      Y_B,
      Y_SCALAR,
      Y_A,
      Y_PLO,
      Y_THI
   } y_sel_type;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   // one micro step of the shared multiply-accumulate unit
   typedef struct packed {
      logic             valid;
      x_sel_type        x_sel;
      y_sel_type        y_sel;
      logic [IDX_W-1:0] a_idx;
      logic [IDX_W-1:0] b_idx;
      logic             hold_en;
      acc_op_type       acc_op;
      logic             shift_hi;
      logic             emit;
      logic             last;
      logic             det;
      logic [IDX_W-1:0] res_idx;
   } step_type;

endpackage

`default_nettype wire

// ===== rtl/m3au_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module m3au_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          req_tvalid,
   input  logic [m3au_pkg::CMD_W-1:0]    req_cmd,
   input  logic [m3au_pkg::OP_W-1:0]     req_op,
   output logic                          req_tready,
   output m3au_pkg::step_type            step
);
   import m3au_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] i;
      logic [IDX_W-1:0] j;
      logic [IDX_W-1:0] k;
      logic             neg;
   } det_term_type;

   // signed triple products of the 3x3 determinant
   function automatic det_term_type det_term(input logic [2:0] t);
      det_term_type d;
      case (t)
         3'd0:    d = '{i: 4'd0, j: 4'd4, k: 4'd8, neg: 1'b0};
         3'd1:    d = '{i: 4'd0, j: 4'd5, k: 4'd7, neg: 1'b1};
         3'd2:    d = '{i: 4'd1, j: 4'd3, k: 4'd8, neg: 1'b1};
         3'd3:    d = '{i: 4'd1, j: 4'd5, k: 4'd6, neg: 1'b0};
         3'd4:    d = '{i: 4'd2, j: 4'd3, k: 4'd7, neg: 1'b0};
         3'd5:    d = '{i: 4'd2, j: 4'd4, k: 4'd6, neg: 1'b1};
         default: d = '{i: 4'd0, j: 4'd0, k: 4'd0, neg: 1'b0};
      endcase
      return d;
   endfunction

   // row-major index row*3+col
   function automatic logic [IDX_W-1:0] idx3(input logic [1:0] r, input logic [1:0] c);
      return {2'b00, r} + {1'b0, r, 1'b0} + {2'b00, c};
   endfunction

   logic         busy_ff, busy_in;
   op_type       op_ff, op_in;
   logic [2:0]   r_ff, r_in;
   logic [1:0]   c_ff, c_in;
   logic [1:0]   k_ff, k_in;
   logic [2:0]   r_max;
   logic [1:0]   c_max;
   logic [1:0]   k_max;
   logic         run_ok;
   logic         final_step;
   logic [IDX_W-1:0] elem;
   det_term_type dt;

   assign req_tready = !busy_ff;
   assign run_ok     = (req_cmd == CMD_RUN) && (req_op <= OP_DET);

   always_comb begin
      case (op_ff)
         OP_ADD, OP_SUB: begin
            k_max = 2'd1; c_max = 2'd2; r_max = 3'd2;
         end
         OP_MUL: begin
            k_max = 2'd2; c_max = 2'd2; r_max = 3'd2;
         end
         OP_MATVEC: begin
            k_max = 2'd2; c_max = 2'd0; r_max = 3'd2;
         end
         OP_DET: begin
            k_max = 2'd3; c_max = 2'd0; r_max = 3'd5;
         end
         default: begin
            k_max = 2'd0; c_max = 2'd2; r_max = 3'd2;
         end
      endcase
   end

   assign final_step = (k_ff == k_max) && (c_ff == c_max) && (r_ff == r_max);
   assign elem       = idx3(r_ff[1:0], c_ff);
   assign dt         = det_term(r_ff);

   // micro step decode
   always_comb begin
      step       = '0;
      step.valid = busy_ff;
      step.last  = final_step;
      step.res_idx = elem;
      case (op_ff)
         OP_ADD, OP_SUB: begin
            step.y_sel = Y_ONE;
            step.a_idx = elem;
            step.b_idx = elem;
            if (k_ff == 2'd0) begin
               step.x_sel  = X_A;
               step.acc_op = ACC_LOAD;
            end else begin
               step.x_sel  = X_B;
               step.acc_op = (op_ff == OP_ADD) ? ACC_ADD : ACC_SUB;
               step.emit   = 1'b1;
            end
         end
         OP_MUL: begin
            step.x_sel  = X_A;
            step.y_sel  = Y_B;
            step.a_idx  = idx3(r_ff[1:0], k_ff);
            step.b_idx  = idx3(k_ff, c_ff);
            step.acc_op = (k_ff == 2'd0) ? ACC_LOAD : ACC_ADD;
            step.emit   = (k_ff == k_max);
         end
         OP_SCALE: begin
            step.x_sel  = X_A;
            step.y_sel  = Y_SCALAR;
            step.a_idx  = elem;
            step.acc_op = ACC_LOAD;
            step.emit   = 1'b1;
         end
         OP_MATVEC: begin
            step.x_sel   = X_A;
            step.y_sel   = Y_B;
            step.a_idx   = idx3(r_ff[1:0], k_ff);
            step.b_idx   = {2'b00, k_ff};
            step.acc_op  = (k_ff == 2'd0) ? ACC_LOAD : ACC_ADD;
            step.emit    = (k_ff == k_max);
            step.res_idx = {1'b0, r_ff};
         end
         OP_TRANS: begin
            step.x_sel  = X_A;
            step.y_sel  = Y_ONE;
            step.a_idx  = idx3(c_ff, r_ff[1:0]);
            step.acc_op = ACC_LOAD;
            step.emit   = 1'b1;
         end
         OP_DET: begin
            step.det     = 1'b1;
            step.res_idx = '0;
            case (k_ff)
               2'd0: begin
                  // park the first factor
                  step.a_idx   = dt.i;
                  step.hold_en = 1'b1;
               end
               2'd1: begin
                  step.x_sel = X_HOLD;
                  step.y_sel = Y_A;
                  step.a_idx = dt.j;
               end
               2'd2: begin
                  // third factor times low half of the pair product
                  step.x_sel  = X_A;
                  step.y_sel  = Y_PLO;
                  step.a_idx  = dt.k;
                  step.acc_op = (r_ff == 3'd0) ? ACC_LOAD : (dt.neg ? ACC_SUB : ACC_ADD);
               end
               default: begin
                  step.x_sel    = X_A;
                  step.y_sel    = Y_THI;
                  step.a_idx    = dt.k;
                  step.shift_hi = 1'b1;
                  step.acc_op   = dt.neg ? ACC_SUB : ACC_ADD;
                  step.emit     = (r_ff == r_max);
               end
            endcase
         end
         default: begin
            step.valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      r_in    = r_ff;
      c_in    = c_ff;
      k_in    = k_ff;
      if (!busy_ff) begin
         if (req_tvalid && run_ok) begin
            busy_in = 1'b1;
            op_in   = op_type'(req_op);
            r_in    = '0;
            c_in    = '0;
            k_in    = '0;
         end
      end else if (adv) begin
         if (k_ff != k_max) begin
            k_in = k_ff + 2'd1;
         end else begin
            k_in = '0;
            if (c_ff != c_max) begin
               c_in = c_ff + 2'd1;
            end else begin
               c_in = '0;
               if (r_ff != r_max) begin
                  r_in = r_ff + 3'd1;
               end else begin
                  busy_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         op_ff   <= OP_ADD;
         r_ff    <= '0;
         c_ff    <= '0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         op_ff   <= op_in;
         r_ff    <= r_in;
         c_ff    <= c_in;
         k_ff    <= k_in;
      end
   end

   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && run_ok |=> busy_ff)
      else $error("run transfer did not start the sequencer");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(step.valid && step.last && adv))
      else $error("sequencer went idle before the last step");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      step.valid && step.last |-> step.emit)
      else $error("final step of a run emits no result");

endmodule

`default_nettype wire

// ===== rtl/m3au_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module m3au_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  m3au_pkg::step_type                    step,
   input  logic signed [m3au_pkg::DATA_W-1:0]    a_rd,
   input  logic signed [m3au_pkg::DATA_W-1:0]    b_rd,
   input  logic signed [m3au_pkg::DATA_W-1:0]    scalar,
   output logic signed [m3au_pkg::ACC_W-1:0]     acc,
   output m3au_pkg::step_type                    emit_step
);
   import m3au_pkg::*;

   localparam logic signed [OPND_W-1:0] ONE_Q = OPND_W'(1) <<< FRAC_W;

   logic signed [OPND_W-1:0] x_op;
   logic signed [OPND_W-1:0] y_op;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [DATA_W-1:0] hold_ff, hold_in;
   logic signed [DATA_W-1:0] thi_ff, thi_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  addend;
   step_type                 c1_ff, c1_in;
   step_type                 c2_ff, c2_in;

   always_comb begin
      case (step.x_sel)
         X_A:     x_op = {a_rd[DATA_W-1], a_rd};
         X_B:     x_op = {b_rd[DATA_W-1], b_rd};
         X_HOLD:  x_op = {hold_ff[DATA_W-1], hold_ff};
         default: x_op = '0;
      endcase
      case (step.y_sel)
         Y_ONE:    y_op = ONE_Q;
         Y_B:      y_op = {b_rd[DATA_W-1], b_rd};
         Y_SCALAR: y_op = {scalar[DATA_W-1], scalar};
         Y_A:      y_op = {a_rd[DATA_W-1], a_rd};
         Y_PLO:    y_op = {1'b0, prod_ff[DATA_W-1:0]};
         Y_THI:    y_op = {thi_ff[DATA_W-1], thi_ff};
         default:  y_op = '0;
      endcase
   end

   // upper half of a pair product goes in the second pass, weighted by 2^DATA_W
   assign prod_ext = ACC_W'(prod_ff);
   assign addend   = c1_ff.shift_hi ? (prod_ext <<< DATA_W) : prod_ext;

   always_comb begin
      prod_in = prod_ff;
      hold_in = hold_ff;
      thi_in  = thi_ff;
      acc_in  = acc_ff;
      c1_in   = c1_ff;
      c2_in   = c2_ff;
      if (adv) begin
         prod_in = x_op * y_op;
         c1_in   = step;
         c2_in   = c1_ff;
         if (step.valid && step.hold_en) begin
            hold_in = a_rd;
         end
         if (step.valid && step.y_sel == Y_PLO) begin
            thi_in = prod_ff[2*DATA_W-1:DATA_W];
         end
         if (c1_ff.valid) begin
            case (c1_ff.acc_op)
               ACC_LOAD: acc_in = addend;
               ACC_ADD:  acc_in = acc_ff + addend;
               ACC_SUB:  acc_in = acc_ff - addend;
               default:  acc_in = acc_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
      end else begin
         c1_ff <= c1_in;
         c2_ff <= c2_in;
      end
      prod_ff <= prod_in;
      hold_ff <= hold_in;
      thi_ff  <= thi_in;
      acc_ff  <= acc_in;
   end

   assign acc       = acc_ff;
   assign emit_step = c2_ff;

   a_emit_after_acc: assert property (@(posedge clock) disable iff (reset)
      c2_ff.valid && c2_ff.emit |-> c2_ff.acc_op != ACC_NONE)
      else $error("result emitted from a step that left the accumulator alone");

   a_high_pass_shifted: assert property (@(posedge clock) disable iff (reset)
      c1_ff.valid && c1_ff.y_sel == Y_THI |-> c1_ff.shift_hi && c1_ff.acc_op != ACC_NONE)
      else $error("upper partial product not weighted into the accumulator");

endmodule

`default_nettype wire

// ===== rtl/m3au_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module m3au_out (
   input  logic                                  clock,
   input  logic                                  reset,
   input  m3au_pkg::step_type                    emit_step,
   input  logic signed [m3au_pkg::ACC_W-1:0]     acc,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [m3au_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast,
   output logic                                  adv
);
   import m3au_pkg::*;

   localparam logic signed [ACC_W-1:0] V_MAX =
      {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] V_MIN =
      {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] POS_LIM  = V_MAX >>> FRAC_W;
   localparam logic signed [ACC_W-1:0] NEG_LIM  = V_MIN >>> FRAC_W;
   localparam logic signed [ACC_W-1:0] DET_BIAS = (ACC_W'(1) <<< (3 * FRAC_W)) - ACC_W'(1);

   logic signed [ACC_W-1:0] flo;
   logic signed [ACC_W-1:0] det_sum;
   logic signed [ACC_W-1:0] det_q;
   logic signed [ACC_W-1:0] res_wide;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;
   logic                    rsp_tlast_ff, rsp_tlast_in;
   logic                    load;

   // floor shift for element results, truncation toward zero for the determinant
   assign flo     = acc >>> FRAC_W;
   assign det_sum = acc + (acc[ACC_W-1] ? DET_BIAS : '0);
   assign det_q   = det_sum >>> (3 * FRAC_W);

   always_comb begin
      if (emit_step.det) begin
         if (det_q > POS_LIM) begin
            res_wide = V_MAX;
         end else if (det_q < NEG_LIM) begin
            res_wide = V_MIN;
         end else begin
            res_wide = det_q <<< FRAC_W;
         end
      end else begin
         if (flo > V_MAX) begin
            res_wide = V_MAX;
         end else if (flo < V_MIN) begin
            res_wide = V_MIN;
         end else begin
            res_wide = flo;
         end
      end
   end

   // a held result that is not taken freezes the datapath behind it
   assign adv  = !(emit_step.valid && emit_step.emit && rsp_tvalid_ff && !rsp_tready);
   assign load = emit_step.valid && emit_step.emit && adv;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = RSP_DATA_W'({emit_step.res_idx, res_wide[DATA_W-1:0]});
         rsp_tlast_in  = emit_step.last;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

`default_nettype wire

// ===== rtl/matrix3x3_arith_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  ports                            contents
// req      in         req_tvalid/tready/tdata/tuser    load element or run operation
// rsp      out        rsp_tvalid/tready/tdata/tlast    result elements, last one marked
//
// a run issues one step per cycle, while the output is not stalled, into a single shared
// 33x33 multiplier and accumulator: add/sub 18, mul 27, scale 9, matrix-vector 9,
// transpose 9, determinant 24 steps; a result passes the product, accumulator and output registers to rsp.
// req_tready is low from a run transfer until its last step is issued.
// a result that finds the output register still full freezes sequencer and multiplier.
// reset (synchronous) clears both matrices and all control state.

module matrix3x3_arith_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [3:0] elem_index, [35:4] operand_value, [38:36] op_code, [39] zero
   input  logic [m3au_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] cmd
   input  logic [m3au_pkg::CMD_W-1:0]           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] result_value, [35:32] result_index, [39:36] zero
   output logic [m3au_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);
   import m3au_pkg::*;

   localparam int VAL_LSB = IDX_W;
   localparam int OP_LSB  = IDX_W + DATA_W;

   logic [IDX_W-1:0]         req_idx;
   logic signed [DATA_W-1:0] req_val;
   logic [OP_W-1:0]          req_op;
   logic                     req_xfer;
   logic                     adv;
   step_type                 step;
   step_type                 emit_step;
   logic signed [ACC_W-1:0]  acc;
   logic signed [DATA_W-1:0] a_rd;
   logic signed [DATA_W-1:0] b_rd;

   // operand matrices, row-major
   logic signed [DATA_W-1:0] mat_a_ff [NUM_ELEM];
   logic signed [DATA_W-1:0] mat_a_in [NUM_ELEM];
   logic signed [DATA_W-1:0] mat_b_ff [NUM_ELEM];
   logic signed [DATA_W-1:0] mat_b_in [NUM_ELEM];
   logic signed [DATA_W-1:0] scalar_ff, scalar_in;

   assign req_idx  = req_tdata[IDX_W-1:0];
   assign req_val  = req_tdata[VAL_LSB+DATA_W-1:VAL_LSB];
   assign req_op   = req_tdata[OP_LSB+OP_W-1:OP_LSB];
   assign req_xfer = req_tvalid && req_tready;

   // loads out of range are dropped; the scalar is caught on every run transfer
   always_comb begin
      mat_a_in  = mat_a_ff;
      mat_b_in  = mat_b_ff;
      scalar_in = scalar_ff;
      if (req_xfer && req_idx < IDX_W'(NUM_ELEM)) begin
         if (req_tuser == CMD_LOAD_A) begin
            mat_a_in[req_idx] = req_val;
         end
         if (req_tuser == CMD_LOAD_B) begin
            mat_b_in[req_idx] = req_val;
         end
      end
      if (req_xfer && req_tuser == CMD_RUN) begin
         scalar_in = req_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NUM_ELEM; n++) begin
            mat_a_ff[n] <= '0;
            mat_b_ff[n] <= '0;
         end
      end else begin
         mat_a_ff <= mat_a_in;
         mat_b_ff <= mat_b_in;
      end
      scalar_ff <= scalar_in;
   end

   // one read port per matrix, addressed by the current step
   assign a_rd = mat_a_ff[step.a_idx];
   assign b_rd = mat_b_ff[step.b_idx];

   m3au_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser),
      .req_op     (req_op),
      .req_tready (req_tready),
      .step       (step)
   );

   m3au_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .step      (step),
      .a_rd      (a_rd),
      .b_rd      (b_rd),
      .scalar    (scalar_ff),
      .acc       (acc),
      .emit_step (emit_step)
   );

   m3au_out u_out (
      .clock      (clock),
      .reset      (reset),
      .emit_step  (emit_step),
      .acc        (acc),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .adv        (adv)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import m3au_pkg::*;

   // codes the package has no name for: they must be ignored by the block
   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
   localparam logic [OP_W-1:0]  OP_NONE  = 3'd7;

   localparam int TAIL_CYCLES = 60;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [IDX_W-1:0]  index;
      logic              last;
   } mat_elem_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // predictor copy of the two stored matrices
   logic signed [DATA_W-1:0] mat_a [NUM_ELEM];
   logic signed [DATA_W-1:0] mat_b [NUM_ELEM];

   mat_elem_type elems_due [$];

   int mismatches     = 0;
   int elems_checked  = 0;
   int reqs_taken     = 0;
   int reqs_ignored   = 0;
   int runs_by_op [7] = '{default: 0};

   // sender pacing
   int burst_left = 0;
   bit steady     = 1'b0;

   // receiver stall pattern
   int rx_mode = 0;
   int rx_seg  = 0;

   matrix3x3_arith_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // saturate to the data width and queue one result element
   task automatic queue_elem(input logic signed [127:0] v, input int index, input bit last);
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      mat_elem_type e;
      hi_lim = 128'sd2147483647;
      lo_lim = -hi_lim - 1;
      if (v > hi_lim)
         e.value = 32'h7fff_ffff;
      else if (v < lo_lim)
         e.value = 32'h8000_0000;
      else
         e.value = v[DATA_W-1:0];
      e.index = index[IDX_W-1:0];
      e.last  = last;
      elems_due.push_back(e);
   endtask

   // state update and expected results for one accepted request
   task automatic compute_matrix_results(input logic [CMD_W-1:0] cmd,
                                         input logic [IDX_W-1:0] idx,
                                         input logic signed [DATA_W-1:0] val,
                                         input logic [OP_W-1:0] op);
      logic signed [127:0] ea [NUM_ELEM];
      logic signed [127:0] eb [NUM_ELEM];
      logic signed [127:0] ev;
      logic signed [127:0] acc;
      logic signed [127:0] m0;
      logic signed [127:0] m1;
      logic signed [127:0] m2;
      logic signed [127:0] mag;
      int r;
      int c;
      int k;
      if (cmd == CMD_LOAD_A || cmd == CMD_LOAD_B) begin
         if (idx < NUM_ELEM) begin
            if (cmd == CMD_LOAD_A)
               mat_a[idx] = val;
            else
               mat_b[idx] = val;
         end
         return;
      end
      if (cmd != CMD_RUN)
         return;
      for (k = 0; k < NUM_ELEM; k++) begin
         ea[k] = 128'(mat_a[k]);
         eb[k] = 128'(mat_b[k]);
      end
      ev = 128'(val);
      if (op != OP_NONE)
         runs_by_op[op]++;
      case (op)
         OP_ADD: begin
            for (k = 0; k < 9; k++) queue_elem(ea[k] + eb[k], k, k == 8);
         end
         OP_SUB: begin
            for (k = 0; k < 9; k++) queue_elem(ea[k] - eb[k], k, k == 8);
         end
         OP_MUL: begin
            for (r = 0; r < 3; r++) begin
               for (c = 0; c < 3; c++) begin
                  acc = 0;
                  for (k = 0; k < 3; k++) acc += ea[3*r+k] * eb[3*k+c];
                  queue_elem(acc >>> FRAC_W, 3*r+c, r == 2 && c == 2);
               end
            end
         end
         OP_SCALE: begin
            for (k = 0; k < 9; k++) queue_elem((ea[k] * ev) >>> FRAC_W, k, k == 8);
         end
         OP_MATVEC: begin
            for (r = 0; r < 3; r++) begin
               acc = 0;
               for (k = 0; k < 3; k++) acc += ea[3*r+k] * eb[k];
               queue_elem(acc >>> FRAC_W, r, r == 2);
            end
         end
         OP_TRANS: begin
            for (r = 0; r < 3; r++)
               for (c = 0; c < 3; c++) queue_elem(ea[3*c+r], 3*r+c, r == 2 && c == 2);
         end
         OP_DET: begin
            // exact cofactor expansion, then truncate toward zero to a whole number
            m0  = ea[4] * ea[8] - ea[7] * ea[5];
            m1  = ea[1] * ea[8] - ea[7] * ea[2];
            m2  = ea[1] * ea[5] - ea[4] * ea[2];
            acc = ea[0] * m0 - ea[3] * m1 + ea[6] * m2;
            mag = (acc < 0) ? -acc : acc;
            mag = mag >>> (3 * FRAC_W);
            if (acc < 0)
               mag = -mag;
            queue_elem(mag <<< FRAC_W, 0, 1'b1);
         end
         default: ;
      endcase
   endtask

   // bursts of random length with random gaps, unless a steady stretch is on
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         if (steady)
            gap = 0;
         else if ($urandom_range(0, 3) == 0)
            gap = $urandom_range(5, 20);
         else
            gap = $urandom_range(0, 3);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
   endtask

   // one request transfer; valid stays high so back-to-back requests need no toggle
   task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val, input logic [OP_W-1:0] op);
      logic [REQ_DATA_W-1:0] word;
      pace_sender();
      word = '0;
      word[IDX_W-1:0]                  = idx;
      word[IDX_W+DATA_W-1:IDX_W]       = val;
      word[IDX_W+DATA_W+OP_W-1 -: OP_W] = op;
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= cmd;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      reqs_taken++;
      if (cmd == CMD_NONE || (cmd == CMD_RUN && op == OP_NONE) ||
          (cmd != CMD_RUN && idx >= NUM_ELEM))
         reqs_ignored++;
      compute_matrix_results(cmd, idx, val, op);
   endtask

   // hold the sender off until every outstanding result has been taken
   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (elems_due.size() != 0);
   endtask

   function automatic logic [DATA_W-1:0] rand_q16();
      int w;
      case ($urandom_range(0, 9))
         0, 1: return $urandom();
         2: begin
            case ($urandom_range(0, 4))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'hffff_ffff;
               default: return 32'h0001_0000;
            endcase
         end
         3, 4: begin
            w = $urandom_range(0, 16) - 8;
            return w <<< FRAC_W;
         end
         default: begin
            w = $urandom_range(0, 1 << 19) - (1 << 18);
            return w;
         end
      endcase
   endfunction

   task automatic test_directed_extremes();
      send_req(CMD_LOAD_A, 4'd0, 32'h7fff_ffff, OP_W'($urandom_range(0, 7)));
      send_req(CMD_LOAD_A, 4'd4, 32'h8000_0000, OP_W'($urandom_range(0, 7)));
      send_req(CMD_LOAD_A, 4'd8, 32'h8000_0000, OP_W'($urandom_range(0, 7)));
      send_req(CMD_LOAD_A, 4'd1, 32'hffff_ffff, OP_W'($urandom_range(0, 7)));
      send_req(CMD_LOAD_A, 4'd2, 32'h0000_0001, OP_W'($urandom_range(0, 7)));
      send_req(CMD_LOAD_B, 4'd0, 32'h7fff_ffff, OP_W'($urandom_range(0, 7)));
      send_req(CMD_LOAD_B, 4'd1, 32'h8000_0000, OP_W'($urandom_range(0, 7)));
      send_req(CMD_LOAD_B, 4'd2, 32'h0001_0000, OP_W'($urandom_range(0, 7)));
      // operand value is don't-care except for scale
      send_req(CMD_RUN, 4'd0, $urandom(), OP_ADD);
      send_req(CMD_RUN, 4'd0, $urandom(), OP_SUB);
      send_req(CMD_RUN, 4'd0, $urandom(), OP_MUL);
      send_req(CMD_RUN, 4'd0, 32'h8000_0000, OP_SCALE);
      send_req(CMD_RUN, 4'd0, 32'h7fff_ffff, OP_SCALE);
      send_req(CMD_RUN, 4'd0, $urandom(), OP_MATVEC);
      send_req(CMD_RUN, 4'd0, $urandom(), OP_TRANS);
      send_req(CMD_RUN, 4'd0, $urandom(), OP_DET);
   endtask

   task automatic test_ignored_requests();
      send_req(CMD_LOAD_A, 4'd9, $urandom(), OP_W'($urandom_range(0, 7)));
      send_req(CMD_LOAD_B, 4'd15, $urandom(), OP_W'($urandom_range(0, 7)));
      send_req(CMD_NONE, IDX_W'($urandom_range(0, 15)), $urandom(),
               OP_W'($urandom_range(0, 7)));
      send_req(CMD_RUN, IDX_W'($urandom_range(0, 15)), $urandom(), OP_NONE);
      // stored matrices must be untouched by the above
      send_req(CMD_RUN, 4'd0, $urandom(), OP_TRANS);
   endtask

   // mostly well-formed load sequences each closed by a run, with some noise mixed in
   task automatic test_random_traffic();
      int n_items;
      int n_loads;
      int k;
      n_items = 0;
      steady  = 1'b1;
      while (n_items < 150) begin
         if (n_items >= 40)
            steady = 1'b0;
         n_loads = $urandom_range(0, 6);
         for (k = 0; k < n_loads; k++) begin
            send_req($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A,
                     IDX_W'($urandom_range(0, NUM_ELEM - 1)), rand_q16(),
                     OP_W'($urandom_range(0, 7)));
            n_items++;
         end
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0: send_req(CMD_W'($urandom_range(0, 1)), IDX_W'($urandom_range(9, 15)),
                           $urandom(), OP_W'($urandom_range(0, 7)));
               1: send_req(CMD_NONE, IDX_W'($urandom_range(0, 15)), $urandom(),
                           OP_W'($urandom_range(0, 7)));
               default: send_req(CMD_RUN, IDX_W'($urandom_range(0, 15)), $urandom(),
                                 OP_NONE);
            endcase
         end
         send_req(CMD_RUN, IDX_W'($urandom_range(0, 15)), rand_q16(),
                  OP_W'($urandom_range(0, 6)));
         n_items++;
         if (n_items >= 75 && n_items < 82)
            wait_all_results();
      end
   endtask

   // determinant of a fractional matrix, full drain, then a run from an idle block
   task automatic test_drain_then_run();
      send_req(CMD_LOAD_A, 4'd0, 32'h0001_8000, OP_W'($urandom_range(0, 7)));
      send_req(CMD_LOAD_A, 4'd4, 32'hfffe_8000, OP_W'($urandom_range(0, 7)));
      send_req(CMD_RUN, 4'd0, $urandom(), OP_DET);
      wait_all_results();
      send_req(CMD_RUN, 4'd0, $urandom(), OP_MUL);
      send_req(CMD_RUN, 4'd0, $urandom(), OP_MATVEC);
   endtask

   // receiver: stall pattern changes mode every segment, mode 0 never stalls
   always @(posedge clock) begin
      if (rx_seg == 0) begin
         rx_mode <= $urandom_range(0, 3);
         rx_seg  <= $urandom_range(8, 80);
      end else begin
         rx_seg <= rx_seg - 1;
      end
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 4) == 0);
         default: rsp_tready <= rx_seg[3];
      endcase
   end

   // compare every result transfer against the oldest outstanding element
   always @(posedge clock) begin
      mat_elem_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         elems_checked++;
         if (elems_due.size() == 0) begin
            report_mismatch("result with nothing outstanding", rsp_tdata[DATA_W-1:0], '0);
         end else begin
            want = elems_due.pop_front();
            if (rsp_tdata[DATA_W-1:0] !== want.value)
               report_mismatch("result_value", rsp_tdata[DATA_W-1:0], want.value);
            if (rsp_tdata[DATA_W+IDX_W-1:DATA_W] !== want.index)
               report_mismatch("result_index", DATA_W'(rsp_tdata[DATA_W+IDX_W-1:DATA_W]),
                               DATA_W'(want.index));
            if (rsp_tlast !== want.last)
               report_mismatch("last_flag", DATA_W'(rsp_tlast), DATA_W'(want.last));
         end
      end
   end

   initial begin
      for (int k = 0; k < NUM_ELEM; k++) begin
         mat_a[k] = '0;
         mat_b[k] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_ignored_requests();
      test_random_traffic();
      test_drain_then_run();

      req_tvalid <= 1'b0;
      while (elems_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d requests taken, %0d of them ignored by design; %0d result elements checked",
               reqs_taken, reqs_ignored, elems_checked);
      $display("runs: add %0d sub %0d mul %0d scale %0d matvec %0d transpose %0d det %0d",
               runs_by_op[0], runs_by_op[1], runs_by_op[2], runs_by_op[3],
               runs_by_op[4], runs_by_op[5], runs_by_op[6]);
      if (mismatches == 0) begin
         $display("matrix3x3_arith_unit: match");
      end else begin
         $display("matrix3x3_arith_unit: mismatch");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("timeout with %0d result elements outstanding", elems_due.size());
      $display("matrix3x3_arith_unit: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/m3au_pkg.sv
rtl/m3au_seq.sv
rtl/m3au_mac.sv
rtl/m3au_out.sv
rtl/matrix3x3_arith_unit.sv
tb/sv/tb.sv
